FILE: rtl/core/msu_pkg.sv
// shared types and constants for the motor supervisor stall and unwrap unit
`default_nettype none
package msu_pkg;

  localparam int AngleWidth        = 48;
  localparam int StallClearCurrent = 1000;
  localparam int SingleWidth       = 19;
  localparam int RawWidth          = 13;
  localparam int CountWidth        = 16;
  localparam int CfgIndexWidth     = 3;
  localparam int CfgDataWidth      = 16;

  localparam logic [SingleWidth-1:0] FullCounts = SingleWidth'(8192);
  localparam logic [SingleWidth:0]   FullDegQ10 = (SingleWidth+1)'(368640);
  localparam logic [SingleWidth-1:0] DegPerCount = SingleWidth'(45);

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_RELAX    = 2'd1,
    MODE_ACTIVATE = 2'd2
  } mode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_STALL_EN      = 3'd0,
    CFG_STALL_CURRENT = 3'd1,
    CFG_STALL_TICKS   = 3'd2,
    CFG_DEGREE_MODE   = 3'd3,
    CFG_MULTITURN     = 3'd4,
    CFG_ENC_OFFSET    = 3'd5,
    CFG_TIMEOUT       = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic                 force_req;
    logic [31:0]          now_ms;
    logic [31:0]          last_online_ms;
    logic signed [15:0]   motor_current;
    logic [RawWidth-1:0]  raw_angle;
  } in_t;

  typedef struct packed {
    logic                          motor_enabled;
    logic                          drive_allowed;
    logic                          timeout_error;
    logic                          stall_error;
    logic                          disable_pulse;
    logic                          enable_pulse;
    logic [SingleWidth-1:0]        single_angle;
    logic signed [AngleWidth-1:0]  total_angle;
  } out_t;

  typedef struct packed {
    logic                 stall_detect_enable;
    logic [14:0]          stall_current_limit;
    logic [13:0]          stall_tick_limit;
    logic                 degree_mode;
    logic                 multiturn_enable;
    logic [RawWidth-1:0]  encoder_offset;
    logic [15:0]          offline_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic                    force_req;
    logic                    timed_out;
    logic                    mag_high;
    logic                    mag_low;
    logic [SingleWidth-1:0]  angle;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/core/msu_front.sv
// input decode: timeout and current compares, encoder angle conversion
`default_nettype none
module msu_front import msu_pkg::*; (
  input  var in_t   data,
  input  var cfg_t  cfg,
  output var item_t item
);

  logic [31:0]          elapsed;
  logic [16:0]          mag;
  logic [RawWidth-1:0]  rel;
  logic [SingleWidth-1:0] deg;

  always_comb begin
    elapsed = data.now_ms - data.last_online_ms;
    if (data.motor_current[15]) begin
      mag = 17'd0 - {data.motor_current[15], data.motor_current};
    end else begin
      mag = {1'b0, data.motor_current};
    end
    // 13-bit subtract wraps modulo one turn
    rel = data.raw_angle - cfg.encoder_offset;
    deg = SingleWidth'(rel) * DegPerCount;

    item.mode      = data.mode;
    item.force_req = data.force_req;
    item.timed_out = elapsed > {16'd0, cfg.offline_timeout_ms};
    item.mag_high  = mag > {2'b00, cfg.stall_current_limit};
    item.mag_low   = mag < 17'(StallClearCurrent);
    item.angle     = cfg.degree_mode ? deg : SingleWidth'(data.raw_angle);
  end

endmodule
`default_nettype wire

FILE: rtl/core/motor_supervisor_stall_unwrap_unit.sv
// top level: motor supervisor with offline timeout, stall detection and angle unwrapping
// path: input is accepted into the decode register, its result into the result register
// throughput: one transaction per cycle; a decode register and the result register
//   let a new transaction in while a result waits on out_stall, else in_stall is raised
// reset: rst clears all supervisor state, angles and flags; configuration returns to
//   stall off, limit 10000, 100 ticks, count units, single turn, offset 0, 500 ms timeout
`default_nettype none
module motor_supervisor_stall_unwrap_unit import msu_pkg::*; (
  input  var logic                      clk,
  input  var logic                      rst,
  input  var logic                      in_valid,
  output var logic                      in_stall,
  input  var in_t                       in_data,
  output var logic                      out_valid,
  input  var logic                      out_stall,
  output var out_t                      out_data,
  input  var logic                      cfg_valid,
  output var logic                      cfg_ready,
  input  var logic [CfgIndexWidth-1:0]  cfg_index,
  input  var logic [CfgDataWidth-1:0]   cfg_data
);

  cfg_t  cfg;
  item_t front_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  logic                   relaxed, force_hold, timeout_flag, stall_flag;
  logic [CountWidth-1:0]  stall_counter;
  logic [SingleWidth-1:0] previous_angle, single_angle_reg;
  logic [AngleWidth-1:0]  accumulated_angle;

  logic                   relaxed_next, force_hold_next, timeout_flag_next, stall_flag_next;
  logic [CountWidth-1:0]  stall_counter_next;
  logic [SingleWidth-1:0] previous_angle_next, single_angle_reg_next;
  logic [AngleWidth-1:0]  accumulated_angle_next;
  logic                   pulse_off, pulse_on, do_angle;

  logic [CountWidth-1:0]  cnt_inc;
  logic [16:0]            clear_limit;
  logic signed [21:0]     delta;
  logic signed [21:0]     full;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = item_valid && !advance;

  msu_front u_front (
    .data (in_data),
    .cfg  (cfg),
    .item (front_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_detect_enable <= 1'b0;
      cfg.stall_current_limit <= 15'd10000;
      cfg.stall_tick_limit    <= 14'd100;
      cfg.degree_mode         <= 1'b0;
      cfg.multiturn_enable    <= 1'b0;
      cfg.encoder_offset      <= '0;
      cfg.offline_timeout_ms  <= 16'd500;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_STALL_EN:      cfg.stall_detect_enable <= cfg_data[0];
        CFG_STALL_CURRENT: cfg.stall_current_limit <= cfg_data[14:0];
        CFG_STALL_TICKS:   cfg.stall_tick_limit    <= cfg_data[13:0];
        CFG_DEGREE_MODE:   cfg.degree_mode         <= cfg_data[0];
        CFG_MULTITURN:     cfg.multiturn_enable    <= cfg_data[0];
        CFG_ENC_OFFSET:    cfg.encoder_offset      <= cfg_data[RawWidth-1:0];
        CFG_TIMEOUT:       cfg.offline_timeout_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // next supervisor state for the transaction in the decode register
  always_comb begin
    relaxed_next           = relaxed;
    force_hold_next        = force_hold;
    timeout_flag_next      = timeout_flag;
    stall_flag_next        = stall_flag;
    stall_counter_next     = stall_counter;
    previous_angle_next    = previous_angle;
    single_angle_reg_next  = single_angle_reg;
    accumulated_angle_next = accumulated_angle;
    pulse_off              = 1'b0;
    pulse_on               = 1'b0;
    do_angle               = 1'b0;
    cnt_inc                = stall_counter + CountWidth'(1);
    clear_limit            = 17'(cfg.stall_tick_limit) * 17'd5;
    full                   = cfg.degree_mode ? 22'(FullDegQ10) : 22'(FullCounts);
    delta                  = 22'(previous_angle) - 22'(item.angle);

    case (mode_t'(item.mode))
      MODE_TICK: begin
        if (item.timed_out) begin
          if (!relaxed_next) begin
            relaxed_next = 1'b1;
            pulse_off    = 1'b1;
          end
          timeout_flag_next = 1'b1;
        end else begin
          do_angle = 1'b1;
          if (timeout_flag) begin
            if (relaxed_next && !force_hold_next) begin
              relaxed_next    = 1'b0;
              force_hold_next = 1'b0;
              pulse_on        = 1'b1;
            end
            timeout_flag_next = 1'b0;
          end
          if (cfg.stall_detect_enable) begin
            if (stall_flag) begin
              if (item.mag_low) begin
                stall_counter_next = cnt_inc;
                if ({1'b0, cnt_inc} == clear_limit) begin
                  if (relaxed_next && !force_hold_next) begin
                    relaxed_next    = 1'b0;
                    force_hold_next = 1'b0;
                    pulse_on        = 1'b1;
                  end
                  stall_flag_next    = 1'b0;
                  stall_counter_next = '0;
                end
              end else begin
                stall_counter_next = '0;
                do_angle           = 1'b0;
              end
            end else begin
              if (item.mag_high) begin
                stall_counter_next = cnt_inc;
                if (cnt_inc == CountWidth'(cfg.stall_tick_limit)) begin
                  if (!relaxed_next) begin
                    relaxed_next = 1'b1;
                    pulse_off    = 1'b1;
                  end
                  stall_flag_next    = 1'b1;
                  stall_counter_next = '0;
                  do_angle           = 1'b0;
                end
              end else begin
                stall_counter_next = '0;
              end
            end
          end
        end
      end
      MODE_RELAX: begin
        if (item.force_req) begin
          force_hold_next = 1'b1;
        end
        if (!relaxed) begin
          relaxed_next = 1'b1;
          pulse_off    = 1'b1;
        end
      end
      MODE_ACTIVATE: begin
        if (relaxed && (!force_hold || item.force_req)) begin
          relaxed_next    = 1'b0;
          force_hold_next = 1'b0;
          pulse_on        = 1'b1;
        end
      end
      default: ;
    endcase

    // shortest-path unwrap into the multi-turn accumulator; single turn copies the angle
    if (do_angle) begin
      single_angle_reg_next = item.angle;
      if (cfg.multiturn_enable) begin
        if ((delta <<< 1) > full) begin
          delta = delta - full;
        end
        if ((delta <<< 1) < -full) begin
          delta = delta + full;
        end
        accumulated_angle_next = accumulated_angle - AngleWidth'(delta);
        previous_angle_next    = item.angle;
      end else begin
        accumulated_angle_next = AngleWidth'(item.angle);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid        <= 1'b0;
      out_valid         <= 1'b0;
      relaxed           <= 1'b0;
      force_hold        <= 1'b0;
      timeout_flag      <= 1'b0;
      stall_flag        <= 1'b0;
      stall_counter     <= '0;
      previous_angle    <= '0;
      single_angle_reg  <= '0;
      accumulated_angle <= '0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
      if (item_valid && advance) begin
        relaxed           <= relaxed_next;
        force_hold        <= force_hold_next;
        timeout_flag      <= timeout_flag_next;
        stall_flag        <= stall_flag_next;
        stall_counter     <= stall_counter_next;
        previous_angle    <= previous_angle_next;
        single_angle_reg  <= single_angle_reg_next;
        accumulated_angle <= accumulated_angle_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= front_item;
    end
    if (item_valid && advance) begin
      out_data.motor_enabled <= !relaxed_next;
      out_data.drive_allowed <= !relaxed_next && !timeout_flag_next && !stall_flag_next;
      out_data.timeout_error <= timeout_flag_next;
      out_data.stall_error   <= stall_flag_next;
      out_data.disable_pulse <= pulse_off;
      out_data.enable_pulse  <= pulse_on;
      out_data.single_angle  <= single_angle_reg_next;
      out_data.total_angle   <= accumulated_angle_next;
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// testbench for the motor supervisor: checks every result against a local model of the unit
`timescale 1ns / 100ps
module tb_top;
  import msu_pkg::*;

  localparam logic [1:0] ModeUnknown = 2'd3;
  localparam int ClearCurrent = 1000;
  localparam longint TurnCounts = 8192;
  localparam longint TurnDegQ10 = 368640;
  localparam int unsigned CycleLimit = 300000;
  localparam int HoldCycles = 120;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  motor_supervisor_stall_unwrap_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // configuration and supervisor state as the unit should hold them
  cfg_t settings = '{stall_detect_enable: 1'b0, stall_current_limit: 15'd10000,
                     stall_tick_limit: 14'd100, degree_mode: 1'b0, multiturn_enable: 1'b0,
                     encoder_offset: 13'd0, offline_timeout_ms: 16'd500};
  logic motor_off = 1'b0;
  logic hold_forced = 1'b0;
  logic offline_err = 1'b0;
  logic stall_err = 1'b0;
  logic [15:0] stall_run = '0;
  logic [18:0] last_pos = '0;
  logic [18:0] cur_pos = '0;
  logic [47:0] turns_acc = '0;
  logic fell_off, came_on;

  in_t pending_items[$];
  out_t expected_status[$];
  int mismatches = 0;
  int unsigned cycles = 0;
  bit in_taken = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;
  int unsigned clock_ms = 0;
  int shaft_pos = 0;

  function automatic void relax_motor(bit forced);
    if (forced) hold_forced = 1'b1;
    if (!motor_off) begin
      motor_off = 1'b1;
      fell_off = 1'b1;
    end
  endfunction

  function automatic void wake_motor(bit forced);
    if (motor_off && (!hold_forced || forced)) begin
      motor_off = 1'b0;
      hold_forced = 1'b0;
      came_on = 1'b1;
    end
  endfunction

  function automatic void track_angle(logic [12:0] raw);
    int x;
    longint span, d;
    if (settings.degree_mode) begin
      x = int'(raw) - int'(settings.encoder_offset);
      if (x < 0) x += 8192;
      cur_pos = 19'(x * 45);
    end else begin
      cur_pos = 19'(raw);
    end
    if (settings.multiturn_enable) begin
      span = settings.degree_mode ? TurnDegQ10 : TurnCounts;
      d = longint'(last_pos) - longint'(cur_pos);
      if (2 * d > span) d -= span;
      if (2 * d < -span) d += span;
      turns_acc = turns_acc - 48'(d);
      last_pos = cur_pos;
    end else begin
      turns_acc = 48'(cur_pos);
    end
  endfunction

  function automatic out_t supervise(in_t it);
    out_t r;
    logic [31:0] elapsed;
    int amp;
    bit move_on;
    fell_off = 1'b0;
    came_on = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        elapsed = it.now_ms - it.last_online_ms;
        amp = int'(it.motor_current);
        if (amp < 0) amp = -amp;
        if (elapsed > 32'(settings.offline_timeout_ms)) begin
          relax_motor(1'b0);
          offline_err = 1'b1;
        end else begin
          move_on = 1'b1;
          if (offline_err) begin
            wake_motor(1'b0);
            offline_err = 1'b0;
          end
          if (settings.stall_detect_enable) begin
            if (stall_err) begin
              if (amp < ClearCurrent) begin
                stall_run = stall_run + 16'd1;
                if (32'(stall_run) == 32'(settings.stall_tick_limit) * 5) begin
                  wake_motor(1'b0);
                  stall_err = 1'b0;
                  stall_run = '0;
                end
              end else begin
                stall_run = '0;
                move_on = 1'b0;
              end
            end else if (amp > int'(settings.stall_current_limit)) begin
              stall_run = stall_run + 16'd1;
              if (32'(stall_run) == 32'(settings.stall_tick_limit)) begin
                relax_motor(1'b0);
                stall_err = 1'b1;
                stall_run = '0;
                move_on = 1'b0;
              end
            end else begin
              stall_run = '0;
            end
          end
          if (move_on) track_angle(it.raw_angle);
        end
      end
      MODE_RELAX: relax_motor(it.force_req);
      MODE_ACTIVATE: wake_motor(it.force_req);
      default: ;
    endcase
    r.motor_enabled = !motor_off;
    r.drive_allowed = !motor_off && !offline_err && !stall_err;
    r.timeout_error = offline_err;
    r.stall_error = stall_err;
    r.disable_pulse = fell_off;
    r.enable_pulse = came_on;
    r.single_angle = cur_pos;
    r.total_angle = turns_acc;
    return r;
  endfunction

  function automatic bit pause_now();
    return !(cycles >= 1000 && cycles < 1500) && ($urandom_range(99) < 15);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // feed transactions from the pending queue
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && !pause_now()) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver side, with one long hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HoldCycles) hold_done = 1'b1;
    end else begin
      out_stall <= pause_now();
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        if (out_data.motor_enabled !== want.motor_enabled) begin
          $error("motor_enabled expected %0d got %0d", want.motor_enabled,
                 out_data.motor_enabled);
          mismatches++;
        end
        if (out_data.drive_allowed !== want.drive_allowed) begin
          $error("drive_allowed expected %0d got %0d", want.drive_allowed,
                 out_data.drive_allowed);
          mismatches++;
        end
        if (out_data.timeout_error !== want.timeout_error) begin
          $error("timeout_error expected %0d got %0d", want.timeout_error,
                 out_data.timeout_error);
          mismatches++;
        end
        if (out_data.stall_error !== want.stall_error) begin
          $error("stall_error expected %0d got %0d", want.stall_error, out_data.stall_error);
          mismatches++;
        end
        if (out_data.disable_pulse !== want.disable_pulse) begin
          $error("disable_pulse expected %0d got %0d", want.disable_pulse,
                 out_data.disable_pulse);
          mismatches++;
        end
        if (out_data.enable_pulse !== want.enable_pulse) begin
          $error("enable_pulse expected %0d got %0d", want.enable_pulse, out_data.enable_pulse);
          mismatches++;
        end
        if (out_data.single_angle !== want.single_angle) begin
          $error("single_angle expected %0d got %0d", want.single_angle, out_data.single_angle);
          mismatches++;
        end
        if (out_data.total_angle !== want.total_angle) begin
          $error("total_angle expected %0d got %0d", want.total_angle, out_data.total_angle);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && !in_stall) expected_status.push_back(supervise(in_data));
    in_taken = in_valid && !in_stall;
  end

  function automatic in_t tick_item(logic [31:0] now, logic [31:0] last,
                                    logic signed [15:0] amps, logic [12:0] raw);
    in_t it;
    it.mode = MODE_TICK;
    it.force_req = 1'($urandom_range(1));
    it.now_ms = now;
    it.last_online_ms = last;
    it.motor_current = amps;
    it.raw_angle = raw;
    return it;
  endfunction

  function automatic in_t cmd_item(logic [1:0] op, bit forced);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom});
    it.mode = op;
    it.force_req = forced;
    return it;
  endfunction

  // profile 0: above the stall limit, 1: below the clear level, else anything
  function automatic logic signed [15:0] draw_current(int profile);
    int lim, m;
    lim = int'(settings.stall_current_limit);
    if (profile == 0) begin
      if (lim >= 32767) m = 32768;
      else if ($urandom_range(3) == 0) m = lim + 1;
      else m = $urandom_range(32768, lim + 1);
    end else if (profile == 1) begin
      m = ($urandom_range(3) == 0) ? ClearCurrent - 1 : $urandom_range(ClearCurrent - 1);
    end else begin
      return 16'($urandom);
    end
    if (m == 32768) return 16'sh8000;
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic in_t make_tick(bit offline, int profile);
    int unsigned gap;
    clock_ms += $urandom_range(20, 1);
    if ($urandom_range(49) == 0) clock_ms = $urandom;
    if (offline) gap = 32'(settings.offline_timeout_ms) + 1 + $urandom_range(5000);
    else if ($urandom_range(9) == 0) gap = 32'(settings.offline_timeout_ms);
    else gap = $urandom_range(32'(settings.offline_timeout_ms));
    if ($urandom_range(7) == 0) shaft_pos = $urandom_range(8191);
    else shaft_pos = (shaft_pos + 8192 + int'($urandom_range(600)) - 300) % 8192;
    return tick_item(clock_ms, clock_ms - gap, draw_current(profile), 13'(shaft_pos));
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STALL_EN: settings.stall_detect_enable = value[0];
      CFG_STALL_CURRENT: settings.stall_current_limit = value[14:0];
      CFG_STALL_TICKS: settings.stall_tick_limit = value[13:0];
      CFG_DEGREE_MODE: settings.degree_mode = value[0];
      CFG_MULTITURN: settings.multiturn_enable = value[0];
      CFG_ENC_OFFSET: settings.encoder_offset = value[12:0];
      CFG_TIMEOUT: settings.offline_timeout_ms = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(bit en, int lim, int ticks, bit deg, bit mt, int off, int tmo);
    write_reg(CFG_STALL_EN, 16'(en));
    write_reg(CFG_STALL_CURRENT, 16'(lim));
    write_reg(CFG_STALL_TICKS, 16'(ticks));
    write_reg(CFG_DEGREE_MODE, 16'(deg));
    write_reg(CFG_MULTITURN, 16'(mt));
    write_reg(CFG_ENC_OFFSET, 16'(off));
    write_reg(CFG_TIMEOUT, 16'(tmo));
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // stall episodes of random length dominate, with timeouts, commands and noise mixed in
  task automatic random_phase(int count);
    int made, kind;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(19);
      if (kind <= 10) begin
        repeat ($urandom_range(6, 1)) begin
          pending_items.push_back(make_tick($urandom_range(29) == 0, 0));
          made++;
        end
        repeat ($urandom_range(15, 1)) begin
          pending_items.push_back(make_tick($urandom_range(29) == 0, 1));
          made++;
        end
      end else if (kind <= 13) begin
        repeat ($urandom_range(3, 1)) begin
          pending_items.push_back(make_tick(1'b1, 2));
          made++;
        end
        repeat ($urandom_range(3, 1)) begin
          pending_items.push_back(make_tick(1'b0, 2));
          made++;
        end
      end else if (kind <= 16) begin
        repeat ($urandom_range(3, 1)) begin
          pending_items.push_back(cmd_item($urandom_range(1) ? MODE_RELAX : MODE_ACTIVATE,
                                           1'($urandom_range(1))));
          made++;
        end
      end else begin
        repeat ($urandom_range(5, 1)) begin
          pending_items.push_back(in_t'({$urandom, $urandom, $urandom}));
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_all(1'b1, 32767, 1, 1'b1, 1'b1, 8191, 65535);
    pending_items.push_back(tick_item(32'd1000, 32'd990, 16'sd0, 13'd0));
    pending_items.push_back(tick_item(32'd1010, 32'd1000, 16'sd32767, 13'd8191));
    // offline, then back online with a stall trip in the same tick
    pending_items.push_back(tick_item(32'h0001_2000, 32'h0000_0000, 16'sd0, 13'd10));
    pending_items.push_back(tick_item(32'h0001_2010, 32'h0001_2000, 16'sh8000, 13'd4096));
    pending_items.push_back(tick_item(32'h0001_2020, 32'h0001_2010, 16'sd999, 13'd1));
    pending_items.push_back(tick_item(32'h0001_2030, 32'h0001_2020, 16'sd1000, 13'd2));
    pending_items.push_back(tick_item(32'h0001_2040, 32'h0001_2030, -16'sd999, 13'd3));
    pending_items.push_back(tick_item(32'h0001_2050, 32'h0001_2040, 16'sd0, 13'd8000));
    pending_items.push_back(tick_item(32'h0001_2060, 32'h0001_2050, 16'sd500, 13'd100));
    pending_items.push_back(tick_item(32'h0001_2070, 32'h0001_2060, 16'sd999, 13'd4095));
    pending_items.push_back(tick_item(32'h0001_2080, 32'h0001_2070, -16'sd1, 13'd4097));
    // forced relax holds against plain activation and timeout recovery
    pending_items.push_back(cmd_item(MODE_RELAX, 1'b1));
    pending_items.push_back(cmd_item(MODE_ACTIVATE, 1'b0));
    pending_items.push_back(tick_item(32'h0003_0000, 32'h0001_0000, 16'sd0, 13'd5));
    pending_items.push_back(tick_item(32'h0003_0010, 32'h0003_0000, 16'sd0, 13'd6));
    pending_items.push_back(cmd_item(MODE_ACTIVATE, 1'b1));
    pending_items.push_back(cmd_item(ModeUnknown, 1'b1));
    pending_items.push_back(cmd_item(MODE_RELAX, 1'b0));
    pending_items.push_back(cmd_item(MODE_ACTIVATE, 1'b0));
    pending_items.push_back(tick_item(32'd3, 32'hFFFF_FFFE, 16'sd123, 13'd5000));
    pending_items.push_back(tick_item(32'hFFFF_FFFF, 32'hFFFF_0000, 16'sd0, 13'd8191));
    pending_items.push_back(tick_item(32'hFFFF_FFFF, 32'hFFFE_FFFF, 16'sd0, 13'd0));
    pending_items.push_back(tick_item(32'h0000_0000, 32'hFFFF_FFFF, -16'sd32767, 13'd1));
    settle();

    program_all(1'b1, 2000, 3, 1'b0, 1'b1, 0, 100);
    hold_go = 1'b1;
    random_phase(250);
    settle();

    program_all(1'b1, 0, 1, 1'b1, 1'b1, 4000, 0);
    random_phase(200);
    settle();

    // units change while unwrapping
    program_all(1'b0, 32767, 16383, 1'b0, 1'b1, 123, 1000);
    random_phase(200);
    settle();

    program_all(1'b1, 15000, 13107, 1'b1, 1'b0, 8191, 65535);
    random_phase(200);
    settle();

    program_all(1'b1, 5000, 0, 1'b1, 1'b1, 1, 1000);
    random_phase(200);
    settle();

    program_all(1'b1, 1000, 2, 1'b0, 1'b1, 7, 300);
    random_phase(250);
    settle();

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
